// File: rtl/cfe_pkg.sv
// shared types and constants of the csv field escaper
`timescale 1ns / 1ps

package cfe_pkg;

    localparam int CHAR_W  = 16;
    localparam int COUNT_W = 16;
    localparam int SLOTS   = 4;
    localparam int NUM_W   = 3;

    localparam logic [CHAR_W-1:0] CH_QUOTE = 16'h0022;
    localparam logic [CHAR_W-1:0] CH_CR    = 16'h000D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_COMMA = 16'h002C;

    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 16'd1020;

    typedef enum logic [2:0] {
        REG_DROP_CONTROL = 3'd0,
        REG_DROP_COMMA   = 3'd1,
        REG_QUOTE_MODE   = 3'd2,
        REG_DROP_CR      = 3'd3,
        REG_CAPACITY     = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic               drop_control;
        logic               drop_comma;
        logic               quote_mode;
        logic               drop_cr;
        logic [COUNT_W-1:0] capacity;
    } cfg_t;

    // one input transaction after decode: compacted characters to emit
    typedef struct packed {
        logic [SLOTS-1:0][CHAR_W-1:0] chars;
        logic [NUM_W-1:0]             num;
        logic [COUNT_W-1:0]           base;
        logic                         last;
    } decoded_t;

endpackage

// File: rtl/cfe_decode.sv
// decode of one input character into the list of characters to emit
`timescale 1ns / 1ps

module cfe_decode
    import cfe_pkg::*;
(
    input  logic [CHAR_W-1:0]  char_in,
    input  logic               first_char,
    input  logic               last_char,
    input  logic               empty_field,
    input  cfg_t               cfg,
    input  logic [COUNT_W-1:0] count,
    output decoded_t           dec
);

    logic                         first_eff;
    logic                         last_eff;
    logic                         keep;
    logic [SLOTS-1:0]             cand_en;
    logic [SLOTS-1:0][CHAR_W-1:0] cand_ch;
    logic [SLOTS-1:0][CHAR_W-1:0] chars;
    logic [NUM_W-1:0]             k;
    logic [COUNT_W-1:0]           base;
    logic [COUNT_W-1:0]           room;

    assign first_eff = first_char | empty_field;
    assign last_eff  = last_char | empty_field;

    assign keep = !(cfg.drop_control && (char_in < CH_SPACE))
               && !(cfg.drop_comma && (char_in == CH_COMMA))
               && !(cfg.drop_cr && (char_in == CH_CR));

    // candidates in emission order: open quote, escape quote, char, close quote
    assign cand_en[0] = first_eff && cfg.quote_mode;
    assign cand_en[1] = !empty_field && cfg.quote_mode && (char_in == CH_QUOTE);
    assign cand_en[2] = !empty_field && keep;
    assign cand_en[3] = last_eff && cfg.quote_mode;
    assign cand_ch[0] = CH_QUOTE;
    assign cand_ch[1] = CH_QUOTE;
    assign cand_ch[2] = char_in;
    assign cand_ch[3] = CH_QUOTE;

    always_comb
    begin
        chars = '0;
        k     = '0;
        for (int j = 0; j < SLOTS; j++)
        begin
            if (cand_en[j])
            begin
                chars[k[1:0]] = cand_ch[j];
                k = k + NUM_W'(1);
            end
        end
    end

    assign base = first_eff ? '0 : count;
    assign room = (base < cfg.capacity) ? (cfg.capacity - base) : '0;

    always_comb
    begin
        dec.chars = chars;
        dec.num   = ({{(COUNT_W-NUM_W){1'b0}}, k} < room) ? k : room[NUM_W-1:0];
        dec.base  = base;
        dec.last  = last_eff;
    end

endmodule

// File: rtl/cfe_emitter.sv
// holding slot and output register that send decoded characters one per cycle while the receiver is ready
`timescale 1ns / 1ps

module cfe_emitter
    import cfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  decoded_t    dec,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // char_out [15:0], field_length [31:16]
    output logic [0:0]  m_tuser,    // char_valid [0]
    output logic        m_tlast
);

    decoded_t           pend_reg;
    logic               pend_valid_reg;
    logic [1:0]         idx_reg;
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               cvalid_reg;
    logic               eof_reg;
    logic [COUNT_W-1:0] len_reg;

    logic [NUM_W-1:0]   total;
    logic [NUM_W-1:0]   last_full;
    logic [1:0]         last_idx;
    logic               out_load;
    logic               advance;
    logic               done;
    logic               accept;

    assign total     = (pend_reg.num == '0) ? NUM_W'(1) : pend_reg.num;
    assign last_full = total - NUM_W'(1);
    assign last_idx  = last_full[1:0];
    assign out_load  = !out_valid_reg || m_tready;
    assign advance   = out_load && pend_valid_reg;
    assign done      = advance && (idx_reg == last_idx);
    assign in_ready  = !pend_valid_reg || done;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pend_valid_reg <= 1'b1;
                idx_reg        <= '0;
            end
            else if (done)
            begin
                pend_valid_reg <= 1'b0;
                idx_reg        <= '0;
            end
            else if (advance)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (out_load)
            begin
                out_valid_reg <= pend_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg <= dec;
        end
        if (advance)
        begin
            if (pend_reg.num == '0)
            begin
                char_reg   <= '0;
                cvalid_reg <= 1'b0;
                len_reg    <= pend_reg.base;
            end
            else
            begin
                char_reg   <= pend_reg.chars[idx_reg];
                cvalid_reg <= 1'b1;
                len_reg    <= pend_reg.base + {{(COUNT_W-2){1'b0}}, idx_reg} + COUNT_W'(1);
            end
            eof_reg <= pend_reg.last && (idx_reg == last_idx);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {len_reg, char_reg};
    assign m_tuser  = cvalid_reg;
    assign m_tlast  = eof_reg;

    a_bubble_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !cvalid_reg |-> char_reg == '0)
        else $error("bubble carries a character code");

    a_char_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && cvalid_reg |-> len_reg != '0)
        else $error("emitted character with zero field length");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> {1'b0, idx_reg} <= last_full)
        else $error("slot index beyond result count");

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_valid_reg |-> idx_reg == '0)
        else $error("slot index not cleared while slot empty");

    a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !done && pend_reg.num != '0 |=> out_valid_reg && cvalid_reg && !eof_reg)
        else $error("middle result of a transaction malformed");

endmodule

// File: rtl/csv_field_escaper.sv
// top level of the csv field escaper: config registers, field count, decode and emitter
`timescale 1ns / 1ps

// usage:
// - slave stream carries one 16-bit code unit per transaction; tlast marks the
//   last character of a field, tuser flags first character and empty field
// - master stream returns one result per transaction: the code unit or a
//   bubble (tuser low), the running field length, tlast on the field's end
// - each input yields 1 to 4 results (opening quote, escape quote, the
//   character, closing quote); the output register sends one result per
//   cycle while the receiver is ready, the results of an item in turn
// - the first result of an item passes the holding slot, then the output
//   register; plain items stream back to back at one per cycle if not stalled
// - the rate is set by the single output register, fed from a one-item
//   holding slot; a new item is taken in the cycle its predecessor's last
//   result moves to the output register
// - receiver stall: results wait in the output register, the slot holds the
//   next item, then s_tready drops; nothing is lost
// - reset: config returns to drop_control=1, drop_comma=1, quote_mode=0,
//   drop_carriage_return=0, capacity=1020; field count clears, streams empty
// - config port: write cfg_data to register cfg_index while cfg_wen is high,
//   only while the streams are idle; indexes beyond the list are ignored
module csv_field_escaper
    import cfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // char_in [15:0]
    input  logic [1:0]  s_tuser,    // first_char [0], empty_field [1]
    input  logic        s_tlast,    // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // char_out [15:0], field_length [31:16]
    output logic [0:0]  m_tuser,    // char_valid [0]
    output logic        m_tlast     // end_of_field
);

    cfg_t               cfg_reg;
    logic [COUNT_W-1:0] count_reg;
    decoded_t           dec;
    logic               accept;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drop_control <= 1'b1;
            cfg_reg.drop_comma   <= 1'b1;
            cfg_reg.quote_mode   <= 1'b0;
            cfg_reg.drop_cr      <= 1'b0;
            cfg_reg.capacity     <= CAPACITY_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_DROP_CONTROL: cfg_reg.drop_control <= cfg_data[0];
                REG_DROP_COMMA:   cfg_reg.drop_comma   <= cfg_data[0];
                REG_QUOTE_MODE:   cfg_reg.quote_mode   <= cfg_data[0];
                REG_DROP_CR:      cfg_reg.drop_cr      <= cfg_data[0];
                REG_CAPACITY:     cfg_reg.capacity     <= cfg_data;
                default:          ;
            endcase
        end
    end

    // running count of characters emitted in the current field
    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= dec.base + {{(COUNT_W-NUM_W){1'b0}}, dec.num};
        end
    end

    cfe_decode u_decode (
        .char_in     (s_tdata),
        .first_char  (s_tuser[0]),
        .last_char   (s_tlast),
        .empty_field (s_tuser[1]),
        .cfg         (cfg_reg),
        .count       (count_reg),
        .dec         (dec)
    );

    cfe_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .dec      (dec),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: bench/csv_field_escaper_tb.sv
// self-checking testbench of the csv field escaper: directed fields, random fields, stalls
`timescale 1ns / 1ps

module csv_field_escaper_tb
    import cfe_pkg::*;
();

    // one source character with its field markers
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              first;
        logic              last;
        logic              empty;
    } field_item_t;

    // one emitted character or bubble
    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic               valid;
        logic               eof;
        logic [COUNT_W-1:0] len;
    } escaped_char_t;

    // receiver behaviors, switched per phase
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC
    } rx_mode_t;

    localparam int LONG_HOLD      = 150;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    // characters waiting to be offered, results still owed by the block
    field_item_t   send_queue[$];
    escaped_char_t expected_chars[$];
    escaped_char_t item_chars[$];

    // shadow of the mode registers and of the field's emitted count
    cfg_t mode_regs = '{drop_control: 1'b1, drop_comma: 1'b1, quote_mode: 1'b0,
                        drop_cr: 1'b0, capacity: CAPACITY_RESET};
    logic [COUNT_W-1:0] field_count = '0;

    int       fail_count = 0;
    int       idle_cycles = 0;
    bit       took_last = 1'b0;
    int       burst_left = 1;
    int       gap_left = 0;
    rx_mode_t rx_mode = RX_ALWAYS;
    int       rx_tick = 0;
    int       hold_left = 0;
    int       hold_requests = 0;
    int       holds_served = 0;

    csv_field_escaper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // char_in [15:0]
        .s_tuser   (s_tuser),   // first_char [0], empty_field [1]
        .s_tlast   (s_tlast),   // last_char
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // char_out [15:0], field_length [31:16]
        .m_tuser   (m_tuser),   // char_valid [0]
        .m_tlast   (m_tlast)    // end_of_field
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // emit one character if the field still has room
    function automatic void push_char(input logic [CHAR_W-1:0] c);
        if (field_count < mode_regs.capacity)
        begin
            field_count = field_count + 16'd1;
            item_chars.push_back('{ch: c, valid: 1'b1, eof: 1'b0, len: field_count});
        end
    endfunction

    // work out everything one accepted character produces and queue it
    function automatic void escape_item(input field_item_t it);
        logic          starts;
        logic          ends;
        logic          keep;
        escaped_char_t tail;
        starts = it.first | it.empty;
        ends = it.last | it.empty;
        item_chars.delete();
        if (starts)
        begin
            field_count = '0;
            // opening quote
            if (mode_regs.quote_mode)
                push_char(CH_QUOTE);
        end
        if (!it.empty)
        begin
            // a carriage return also falls under the control-character filter
            keep = !((mode_regs.drop_control && it.ch < CH_SPACE) ||
                     (mode_regs.drop_comma && it.ch == CH_COMMA) ||
                     (mode_regs.drop_cr && it.ch == CH_CR));
            // embedded quote is doubled, each half only while room remains
            if (mode_regs.quote_mode && it.ch == CH_QUOTE)
                push_char(CH_QUOTE);
            if (keep)
                push_char(it.ch);
        end
        // closing quote
        if (ends && mode_regs.quote_mode)
            push_char(CH_QUOTE);
        // nothing emitted: a bubble carrying the current count
        if (item_chars.size() == 0)
            item_chars.push_back('{ch: '0, valid: 1'b0, eof: 1'b0, len: field_count});
        if (ends)
        begin
            tail = item_chars.pop_back();
            tail.eof = 1'b1;
            item_chars.push_back(tail);
        end
        foreach (item_chars[i])
            expected_chars.push_back(item_chars[i]);
    endfunction

    function automatic void flag_mismatch(input string what, input escaped_char_t want,
                                          input escaped_char_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t %s: expected ch %h v %b eof %b len %0d, got ch %h v %b eof %b len %0d",
                     $time, what, want.ch, want.valid, want.eof, want.len,
                     got.ch, got.valid, got.eof, got.len);
    endfunction

    // input side: a transaction at this edge is predicted and leaves the queue
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            took_last = s_tvalid && s_tready;
            if (took_last)
                escape_item(send_queue.pop_front());
        end
    end

    // sender: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        field_item_t nx;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!(s_tvalid && !took_last))
        begin
            // an offered character stays put until its transaction, handled above
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (send_queue.size() > 0)
            begin
                nx = send_queue[0];
                s_tdata <= nx.ch;
                s_tuser <= {nx.empty, nx.first};
                s_tlast <= nx.last;
                s_tvalid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    // a third of the bursts run straight into the next one
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: per-phase stall pattern, plus long hold-offs on request
    always @(negedge clk)
    begin
        rx_tick++;
        if (!rst_n)
            m_tready <= 1'b0;
        else if (holds_served != hold_requests)
        begin
            holds_served++;
            hold_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS:   m_tready <= 1'b1;
                RX_RANDOM:   m_tready <= ($urandom_range(0, 99) >= 35);
                RX_PERIODIC: m_tready <= ((rx_tick % 7) < 4);
                default:     m_tready <= 1'b1;
            endcase
        end
    end

    // output side: compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        escaped_char_t got;
        escaped_char_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{ch: m_tdata[15:0], valid: m_tuser[0], eof: m_tlast,
                        len: m_tdata[31:16]};
                if (expected_chars.size() == 0)
                    flag_mismatch("unexpected result", '0, got);
                else
                begin
                    want = expected_chars.pop_front();
                    if (got.ch !== want.ch || got.valid !== want.valid ||
                        got.eof !== want.eof || got.len !== want.len)
                        flag_mismatch("result mismatch", want, got);
                end
            end
            // watchdog: no transaction on either side for too long
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("csv_field_escaper regression: fail");
                $finish;
            end
        end
    end

    // wait until every character went in and every result came back
    task automatic drain();
        while (send_queue.size() != 0 || expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
    endtask

    // mode registers change only with the block idle
    task automatic program_modes(input cfg_t c);
        drain();
        write_reg(REG_DROP_CONTROL, {15'd0, c.drop_control});
        write_reg(REG_DROP_COMMA, {15'd0, c.drop_comma});
        write_reg(REG_QUOTE_MODE, {15'd0, c.quote_mode});
        write_reg(REG_DROP_CR, {15'd0, c.drop_cr});
        write_reg(REG_CAPACITY, c.capacity);
        @(negedge clk);
        cfg_wen <= 1'b0;
        mode_regs = c;
        @(posedge clk);
    endtask

    function automatic void add_item(input logic [CHAR_W-1:0] ch, input logic first,
                                     input logic last, input logic empty);
        send_queue.push_back('{ch: ch, first: first, last: last, empty: empty});
    endfunction

    // biased toward the characters the filters and the quoting care about
    function automatic logic [CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 11))
            0:       return CH_QUOTE;
            1:       return CH_COMMA;
            2:       return CH_CR;
            3:       return CH_SPACE;
            4:       return CHAR_W'($urandom_range(0, 31));
            5:       return CHAR_W'($urandom_range(32, 126));
            default: return CHAR_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic cfg_t random_modes();
        cfg_t c;
        c.drop_control = 1'($urandom_range(0, 1));
        c.drop_comma = 1'($urandom_range(0, 1));
        c.quote_mode = 1'($urandom_range(0, 1));
        c.drop_cr = 1'($urandom_range(0, 1));
        c.capacity = ($urandom_range(0, 1) != 0) ? COUNT_W'($urandom_range(1, 12))
                                                 : COUNT_W'($urandom_range(13, 65535));
        return c;
    endfunction

    // mostly well-formed fields with random content, the rest loose characters
    task automatic queue_fields(input int n_items);
        int made;
        int len;
        made = 0;
        while (made < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                add_item(pick_char(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
                made++;
            end
            else
            begin
                len = $urandom_range(0, 10);
                if (len == 0)
                begin
                    // empty field, markers left random since it overrides them
                    add_item(pick_char(), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), 1'b1);
                    made++;
                end
                else
                begin
                    for (int i = 0; i < len; i++)
                        add_item(pick_char(), i == 0, i == len - 1, 1'b0);
                    made += len;
                end
            end
        end
    endtask

    // one random phase; the sender pauses at its start until all results are in
    task automatic run_phase(input cfg_t c, input rx_mode_t m, input int n_items,
                             input bit long_hold);
        program_modes(c);
        rx_mode = m;
        if (long_hold)
            hold_requests++;
        queue_fields(n_items);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset modes: control characters and commas dropped, no quoting
        rx_mode = RX_RANDOM;
        add_item(16'h0041, 1'b1, 1'b0, 1'b0);
        add_item(16'h0000, 1'b0, 1'b0, 1'b0);
        add_item(16'h001F, 1'b0, 1'b0, 1'b0);
        add_item(CH_SPACE, 1'b0, 1'b0, 1'b0);
        add_item(CH_COMMA, 1'b0, 1'b0, 1'b0);
        add_item(CH_CR, 1'b0, 1'b0, 1'b0);
        add_item(16'hFFFF, 1'b0, 1'b1, 1'b0);
        add_item(16'h1234, 1'b1, 1'b1, 1'b0);
        add_item(16'h5555, 1'b0, 1'b0, 1'b1);
        // continuation without a start marker
        add_item(16'h0041, 1'b0, 1'b0, 1'b0);
        add_item(CH_QUOTE, 1'b0, 1'b1, 1'b0);

        // quoting with a tight capacity: escapes split by the limit
        program_modes('{drop_control: 1'b0, drop_comma: 1'b0, quote_mode: 1'b1,
                        drop_cr: 1'b1, capacity: 16'd5});
        add_item(CH_QUOTE, 1'b1, 1'b0, 1'b0);
        add_item(CH_CR, 1'b0, 1'b0, 1'b0);
        add_item(CH_COMMA, 1'b0, 1'b0, 1'b0);
        add_item(CH_QUOTE, 1'b0, 1'b0, 1'b0);
        add_item(16'h0001, 1'b0, 1'b1, 1'b0);
        add_item(CH_QUOTE, 1'b1, 1'b1, 1'b0);
        add_item(16'h0000, 1'b1, 1'b1, 1'b1);
        add_item(16'h0007, 1'b1, 1'b1, 1'b0);

        // zero capacity: only bubbles come back
        program_modes('{drop_control: 1'b0, drop_comma: 1'b0, quote_mode: 1'b1,
                        drop_cr: 1'b0, capacity: 16'd0});
        add_item(CH_QUOTE, 1'b1, 1'b1, 1'b0);
        add_item(16'hABCD, 1'b0, 1'b0, 1'b1);
        add_item(16'hFFFF, 1'b1, 1'b0, 1'b0);

        // random fields across several mode settings
        run_phase('{drop_control: 1'b1, drop_comma: 1'b1, quote_mode: 1'b0,
                    drop_cr: 1'b0, capacity: CAPACITY_RESET}, RX_RANDOM, 55, 1'b0);
        // long receiver hold-off while the sender keeps offering
        run_phase('{drop_control: 1'b0, drop_comma: 1'b0, quote_mode: 1'b1,
                    drop_cr: 1'b0, capacity: 16'hFFFF}, RX_ALWAYS, 55, 1'b1);
        run_phase('{drop_control: 1'b1, drop_comma: 1'b1, quote_mode: 1'b1,
                    drop_cr: 1'b1, capacity: 16'($urandom_range(1, 6))}, RX_PERIODIC, 55, 1'b0);
        run_phase('{drop_control: 1'b0, drop_comma: 1'b1, quote_mode: 1'b1,
                    drop_cr: 1'b0, capacity: 16'd0}, RX_RANDOM, 25, 1'b0);
        run_phase(random_modes(), RX_PERIODIC, 50, 1'b1);
        run_phase(random_modes(), RX_RANDOM, 50, 1'b0);
        run_phase(random_modes(), RX_ALWAYS, 50, 1'b0);

        drain();
        if (expected_chars.size() != 0)
            fail_count += expected_chars.size();
        if (fail_count == 0)
            $display("csv_field_escaper regression: pass");
        else
            $display("csv_field_escaper regression: fail");
        $finish;
    end

endmodule
